FILE: hdl/software_timer_list_manager_macros.svh
// Assertion macros shared by the timer list manager RTL.
`ifndef SOFTWARE_TIMER_LIST_MANAGER_MACROS_SVH
`define SOFTWARE_TIMER_LIST_MANAGER_MACROS_SVH

// cond must hold at every clock edge outside reset
`define STLM_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define STLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stlm_pkg.sv
// Shared types and constants for the timer list manager.
package stlm_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DEF_TASK_COUNT  = 16;
  localparam int MAX_RESULTS     = 16;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_SCHED = 2'd1,
    OP_DEL   = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_EXPIRED   = 2'd1,
    KIND_NO_EXPIRY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED_RD,
    ST_DEL_WALK,
    ST_TICK_WALK,
    ST_TICK_END
  } state_t;

endpackage

FILE: hdl/stlm_ram.sv
// Slot entry memory: one write port, one read port, registered read data.
module stlm_ram #(
  parameter int DEPTH = 16,
  parameter int DATA_W = 8,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/software_timer_list_manager.sv
// Top level: one-shot timer slot list with countdown, schedule and delete.
//
// Channel   Ports                                             Transaction
// -------   -----------------------------------------------   --------------------------
// command   start, busy, opcode, timer_slot, timeout_ticks,     start && !busy at clk edge
//           target_task, notify_message, elapsed
// result    strobe, kind, slot_out, task_out, message_out,      strobe high for one cycle
//           was_active, last
//
// Cycles: schedule of an idle slot, bad slot or task, and delete of an idle
//   slot give their result in the cycle after the command; busy stays low.
// Reschedule of an active slot: read, then write back the entry in ST_SCHED_RD.
// Delete of an active slot: ST_DEL_WALK walks the list entry by entry up to and
//   including it.
// Tick: ST_TICK_WALK visits each active slot once; the single memory read port
//   fetches one list entry per cycle, and the last result comes in a
//   closing cycle.
// Reset (synchronous) clears the active flags and empties the list; no
//   memory sweep is needed. The receiver cannot stall the result strobe.
module software_timer_list_manager #(
  parameter int TIMER_SLOTS = stlm_pkg::DEF_TIMER_SLOTS,
  parameter int TASK_COUNT  = stlm_pkg::DEF_TASK_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [3:0]  timer_slot,
  input  logic [15:0] timeout_ticks,
  input  logic [3:0]  target_task,
  input  logic [15:0] notify_message,
  input  logic [15:0] elapsed,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  slot_out,
  output logic [3:0]  task_out,
  output logic [15:0] message_out,
  output logic        was_active,
  output logic        last
);

  import stlm_pkg::*;

  // Entry layout in memory: {remaining, next link, task, message}
  localparam int IDX_W   = $clog2(TIMER_SLOTS);
  localparam int LINK_W  = $clog2(TIMER_SLOTS + 1);
  localparam int TASK_W  = $clog2(TASK_COUNT);
  localparam int REM_W   = 16;
  localparam int MSG_W   = 16;
  localparam int ENTRY_W = REM_W + LINK_W + TASK_W + MSG_W;
  localparam int CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(TIMER_SLOTS);

  state_t state, state_next;

  // Control state
  logic [TIMER_SLOTS-1:0] active;
  logic [LINK_W-1:0]      head;
  logic                   pend_valid;
  logic [CNT_W-1:0]       res_cnt;

  // Per-transaction working registers
  logic [IDX_W-1:0]   slot_q;
  logic [REM_W-1:0]   load_q;
  logic [REM_W-1:0]   elapsed_q;
  logic [LINK_W-1:0]  cur;
  logic [LINK_W-1:0]  prev;
  logic [ENTRY_W-1:0] prev_entry;
  logic [IDX_W-1:0]   pend_slot;
  logic [TASK_W-1:0]  pend_task;
  logic [MSG_W-1:0]   pend_msg;

  // Memory port
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // Command decode
  logic              accept;
  logic [IDX_W-1:0]  in_slot;
  logic              slot_ok;
  logic              task_ok;
  logic              in_active;
  logic [REM_W-1:0]  load_val;

  // Fields of the entry just read
  logic [REM_W-1:0]   rd_rem;
  logic [LINK_W-1:0]  rd_next;
  logic [TASK_W-1:0]  rd_task;
  logic [MSG_W-1:0]   rd_msg;
  logic [REM_W-1:0]   new_rem;
  logic               expired;
  logic               hit;
  logic               keep_room;
  logic [ENTRY_W-1:0] prev_relinked;

  // Next result
  logic        res_fire;
  kind_t       res_kind;
  logic [3:0]  res_slot;
  logic [3:0]  res_task;
  logic [15:0] res_msg;
  logic        res_was;
  logic        res_last;

  stlm_ram #(
    .DEPTH  (TIMER_SLOTS),
    .DATA_W (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign in_slot   = IDX_W'(timer_slot);
  assign slot_ok   = (32'(timer_slot) < 32'(TIMER_SLOTS));
  assign task_ok   = (32'(target_task) < 32'(TASK_COUNT));
  assign in_active = slot_ok && active[in_slot];
  assign load_val  = (timeout_ticks == '0) ? REM_W'(1) : timeout_ticks;

  assign rd_rem  = ram_rdata[ENTRY_W-1 -: REM_W];
  assign rd_next = ram_rdata[TASK_W+MSG_W +: LINK_W];
  assign rd_task = ram_rdata[MSG_W +: TASK_W];
  assign rd_msg  = ram_rdata[MSG_W-1:0];

  // Saturating countdown; an active entry always holds at least one tick
  assign expired   = (rd_rem <= elapsed_q);
  assign new_rem   = expired ? '0 : (rd_rem - elapsed_q);
  assign hit       = (cur == LINK_W'(slot_q));
  assign keep_room = (res_cnt < CNT_W'(MAX_RESULTS));

  // Predecessor keeps its fields, only its link moves past the current entry
  assign prev_relinked = {prev_entry[ENTRY_W-1 -: REM_W], rd_next,
                          prev_entry[TASK_W+MSG_W-1:0]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_TICK:  state_next = (head == NIL) ? ST_TICK_END : ST_TICK_WALK;
            OP_SCHED: if (in_active && task_ok) state_next = ST_SCHED_RD;
            OP_DEL:   if (in_active) state_next = ST_DEL_WALK;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCHED_RD:  state_next = ST_IDLE;
      ST_DEL_WALK:  if (hit || rd_next == NIL) state_next = ST_IDLE;
      ST_TICK_WALK: if (rd_next == NIL) state_next = ST_TICK_END;
      ST_TICK_END:  state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Memory accesses and result selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    res_fire  = 1'b0;
    res_kind  = KIND_ACK;
    res_slot  = '0;
    res_task  = '0;
    res_msg   = '0;
    res_was   = 1'b0;
    res_last  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            OP_TICK: begin
              ram_re    = (head != NIL);
              ram_raddr = head[IDX_W-1:0];
            end
            OP_SCHED: begin
              if (in_active && task_ok) begin
                ram_re    = 1'b1;
                ram_raddr = in_slot;
              end else begin
                // new activation goes straight to the head of the list
                ram_we    = slot_ok && task_ok;
                ram_waddr = in_slot;
                ram_wdata = {load_val, head, TASK_W'(target_task), notify_message};
                res_fire  = 1'b1;
                res_slot  = timer_slot;
                res_was   = in_active;
                res_last  = 1'b1;
              end
            end
            OP_DEL: begin
              if (in_active) begin
                ram_re    = 1'b1;
                ram_raddr = head[IDX_W-1:0];
              end else begin
                res_fire = 1'b1;
                res_slot = timer_slot;
                res_last = 1'b1;
              end
            end
            default: res_fire = 1'b0;
          endcase
        end
      end
      ST_SCHED_RD: begin
        // reload only the countdown
        ram_we    = 1'b1;
        ram_waddr = slot_q;
        ram_wdata = {load_q, rd_next, rd_task, rd_msg};
        res_fire  = 1'b1;
        res_slot  = 4'(slot_q);
        res_was   = 1'b1;
        res_last  = 1'b1;
      end
      ST_DEL_WALK: begin
        if (hit || rd_next == NIL) begin
          ram_we    = hit && (prev != NIL);
          ram_waddr = prev[IDX_W-1:0];
          ram_wdata = prev_relinked;
          res_fire  = 1'b1;
          res_slot  = 4'(slot_q);
          res_was   = 1'b1;
          res_last  = 1'b1;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_next[IDX_W-1:0];
        end
      end
      ST_TICK_WALK: begin
        if (expired) begin
          ram_we    = (prev != NIL);
          ram_waddr = prev[IDX_W-1:0];
          ram_wdata = prev_relinked;
          // one expiry held back so that the final one can carry last
          res_fire  = keep_room && pend_valid;
          res_kind  = KIND_EXPIRED;
          res_slot  = 4'(pend_slot);
          res_task  = 4'(pend_task);
          res_msg   = pend_msg;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = cur[IDX_W-1:0];
          ram_wdata = {new_rem, rd_next, rd_task, rd_msg};
        end
        ram_re    = (rd_next != NIL);
        ram_raddr = rd_next[IDX_W-1:0];
      end
      ST_TICK_END: begin
        res_fire = 1'b1;
        res_last = 1'b1;
        if (pend_valid) begin
          res_kind = KIND_EXPIRED;
          res_slot = 4'(pend_slot);
          res_task = 4'(pend_task);
          res_msg  = pend_msg;
        end else begin
          res_kind = KIND_NO_EXPIRY;
        end
      end
      default: res_fire = 1'b0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active     <= '0;
      head       <= NIL;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      res_cnt    <= '0;
    end else begin
      state  <= state_next;
      strobe <= res_fire;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            pend_valid <= 1'b0;
            res_cnt    <= '0;
            if (opcode == OP_SCHED && slot_ok && task_ok && !in_active) begin
              active[in_slot] <= 1'b1;
              head            <= LINK_W'(in_slot);
            end
          end
        end
        ST_DEL_WALK: begin
          if (hit) begin
            active[slot_q] <= 1'b0;
            if (prev == NIL) head <= rd_next;
          end
        end
        ST_TICK_WALK: begin
          if (expired) begin
            active[cur[IDX_W-1:0]] <= 1'b0;
            if (prev == NIL) head <= rd_next;
            if (keep_room) begin
              pend_valid <= 1'b1;
              res_cnt    <= res_cnt + CNT_W'(1);
            end
          end
        end
        ST_TICK_END: pend_valid <= 1'b0;
        default: pend_valid <= pend_valid;
      endcase
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    kind        <= res_kind;
    slot_out    <= res_slot;
    task_out    <= res_task;
    message_out <= res_msg;
    was_active  <= res_was;
    last        <= res_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          slot_q    <= in_slot;
          load_q    <= load_val;
          elapsed_q <= elapsed;
          cur       <= head;
          prev      <= NIL;
        end
      end
      ST_DEL_WALK: begin
        if (!hit) begin
          prev       <= cur;
          prev_entry <= ram_rdata;
          cur        <= rd_next;
        end
      end
      ST_TICK_WALK: begin
        if (expired) begin
          if (prev != NIL) prev_entry <= prev_relinked;
          if (keep_room) begin
            pend_slot <= cur[IDX_W-1:0];
            pend_task <= rd_task;
            pend_msg  <= rd_msg;
          end
        end else begin
          prev       <= cur;
          prev_entry <= {new_rem, rd_next, rd_task, rd_msg};
        end
        cur <= rd_next;
      end
      default: cur <= cur;
    endcase
  end

  `include "software_timer_list_manager_macros.svh"

  `STLM_ASSERT_ALWAYS(a_no_rw_overlap, clk, rst, !(ram_we && ram_re && ram_waddr == ram_raddr), "read and write hit the same entry")
  `STLM_ASSERT_ALWAYS(a_head_active, clk, rst, (head == NIL) || active[head[IDX_W-1:0]], "list head is not an active slot")
  `STLM_ASSERT_NEXT(a_tick_no_growth, clk, rst, state == ST_TICK_WALK, $countones(active) <= $past($countones(active)), "tick walk activated a slot")
  `STLM_ASSERT_NEXT(a_tick_closes, clk, rst, state == ST_TICK_END, strobe && last, "tick ended without a final result")

endmodule
